### rtl/core/esr_pkg.sv
// Shared constants, item kind codes and result types for the edge-timed serial receiver.
// No dependencies; esr_frame, esr_fifo, esr_outq and the top level import this package.
package esr_pkg;

    // Item kind codes.
    localparam logic [1:0] KIND_EDGE  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_REARM = 2'd3;

    // Frame constants: bits in one character after the start bit, and field widths.
    localparam logic [3:0] CHAR_FRAME_BITS = 4'd9;
    localparam int CHAR_W = 7;
    localparam int FILL_W = 6;

    // Character FIFO sizing.
    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int DIFF_W = (PTR_W + 1 > FILL_W) ? PTR_W + 1 : FILL_W;

    // Output queue sizing.
    localparam int OUTQ_DEPTH = 3;
    localparam int OQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Character completion seen by the FIFO.
    typedef struct packed {
        logic              done;
        logic [CHAR_W-1:0] value;
        logic              perr;
    } frame_res_t;

    // One result item as presented on the output channel.
    typedef struct packed {
        logic              char_done;
        logic [CHAR_W-1:0] char_value;
        logic              parity_error;
        logic              read_valid;
        logic [CHAR_W-1:0] read_value;
        logic [FILL_W-1:0] fill_count;
        logic              overflow;
    } result_t;

endpackage

### rtl/core/esr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module esr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/esr_frame.sv
// Character assembly: bit counter, bit mask and build register, updated from line edges.
// Also holds the parity check enable register. Depends on esr_pkg.
module esr_frame import esr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       step_en,
    input  logic [1:0] kind,
    input  logic       pin_level,
    input  logic [7:0] bits_elapsed,
    output frame_res_t res
);

    logic       parity_en_reg;
    logic       waiting_reg, waiting_next;
    logic [2:0] count_reg, count_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] build_reg, build_next;

    logic [3:0]  left;
    logic [3:0]  frame;
    logic        next_started;
    logic [4:0]  sum;
    logic [15:0] wide_mask;
    logic [15:0] shifted;
    logic [7:0]  fill_v;
    logic [7:0]  m_new;
    logic [7:0]  v_new;
    logic        complete;
    logic        is_edge;

    // Frame length, mask fill and completion for the current edge.
    always_comb
    begin
        left         = CHAR_FRAME_BITS - {1'b0, count_reg};
        next_started = bits_elapsed > {4'b0, left};
        frame        = next_started ? left : bits_elapsed[3:0];
        if (!pin_level && frame == 4'd0)
        begin
            frame = 4'd1;
        end
        sum    = {2'b0, count_reg} + {1'b0, frame};
        fill_v = '0;
        for (int k = 0; k < 9; k++)
        begin
            shifted = {8'b0, mask_reg} << k;
            if (4'(k) < frame)
            begin
                fill_v = fill_v | shifted[7:0];
            end
        end
        if (pin_level)
        begin
            // High level: every bit of the frame is a zero on the line, set in the build.
            wide_mask = {8'b0, mask_reg} << (frame + 4'd1);
            m_new     = wide_mask[7:0];
            v_new     = build_reg | fill_v;
        end
        else
        begin
            wide_mask = {8'b0, mask_reg} << (frame - 4'd1);
            m_new     = wide_mask[7:0];
            v_new     = build_reg | m_new;
        end
        is_edge   = (kind == KIND_EDGE);
        complete  = is_edge && !waiting_reg && (sum[4] || sum[3]);
        res.done  = complete;
        res.value = v_new[CHAR_W-1:0];
        res.perr  = complete && parity_en_reg && (v_new[7] != (^v_new[CHAR_W-1:0]));
    end

    // Next state of the assembly registers.
    always_comb
    begin
        waiting_next = waiting_reg;
        count_next   = count_reg;
        mask_next    = mask_reg;
        build_next   = build_reg;
        if (step_en)
        begin
            case (kind)
                KIND_EDGE:
                begin
                    if (waiting_reg)
                    begin
                        if (pin_level)
                        begin
                            waiting_next = 1'b0;
                            count_next   = 3'd0;
                            mask_next    = 8'h01;
                            build_next   = 8'h00;
                        end
                    end
                    else
                    begin
                        count_next = sum[2:0];
                        mask_next  = m_new;
                        build_next = v_new;
                        if (complete)
                        begin
                            build_next = {1'b0, v_new[CHAR_W-1:0]};
                            if (!pin_level || !next_started)
                            begin
                                waiting_next = 1'b1;
                            end
                            else
                            begin
                                // The next start bit is already under way.
                                count_next = 3'd0;
                                mask_next  = 8'h01;
                                build_next = 8'h00;
                            end
                        end
                    end
                end
                KIND_REARM:
                begin
                    waiting_next = 1'b1;
                end
                default:
                begin
                    waiting_next = waiting_reg;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_en_reg <= 1'b1;
            waiting_reg   <= 1'b1;
            count_reg     <= 3'd0;
            mask_reg      <= 8'h00;
            build_reg     <= 8'h00;
        end
        else
        begin
            if (cfg_we)
            begin
                parity_en_reg <= cfg_wdata;
            end
            waiting_reg <= waiting_next;
            count_reg   <= count_next;
            mask_reg    <= mask_next;
            build_reg   <= build_next;
        end
    end

endmodule

### rtl/core/esr_fifo.sv
// Ring FIFO of received characters: pointers, sticky overflow and the storage RAM.
// Depends on esr_pkg and esr_ram.
module esr_fifo import esr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [1:0]        kind,
    input  frame_res_t        push,
    output logic              rd_valid,
    output logic [FILL_W-1:0] fill,
    output logic              ovf,
    output logic [CHAR_W-1:0] rd_data
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [DIFF_W-1:0] DEPTH_D = DIFF_W'(FIFO_DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             ovf_reg, ovf_next;
    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W-1:0] head_inc;
    logic             wr_en;
    logic             rd_en;
    logic [DIFF_W-1:0] diff;

    // Pointer updates for push, pop and clear.
    always_comb
    begin
        tail_inc  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
        head_inc  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        head_next = head_reg;
        tail_next = tail_reg;
        ovf_next  = ovf_reg;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_valid  = 1'b0;
        if (step_en)
        begin
            case (kind)
                KIND_EDGE:
                begin
                    if (push.done)
                    begin
                        if (tail_inc == head_reg)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            tail_next = tail_inc;
                        end
                    end
                end
                KIND_POP:
                begin
                    ovf_next = 1'b0;
                    if (head_reg != tail_reg)
                    begin
                        rd_valid  = 1'b1;
                        rd_en     = 1'b1;
                        head_next = head_inc;
                    end
                end
                KIND_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                    ovf_next  = 1'b0;
                end
                default:
                begin
                    ovf_next = ovf_reg;
                end
            endcase
        end
    end

    // Occupancy after this item, reported in its low bits.
    always_comb
    begin
        if (tail_next >= head_next)
        begin
            diff = DIFF_W'(tail_next) - DIFF_W'(head_next);
        end
        else
        begin
            diff = DIFF_W'(tail_next) + DEPTH_D - DIFF_W'(head_next);
        end
        fill = diff[FILL_W-1:0];
        ovf  = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Character storage.
    esr_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(FIFO_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(tail_reg),
        .wdata(push.value),
        .re   (rd_en),
        .raddr(head_reg),
        .rdata(rd_data)
    );

endmodule

### rtl/core/esr_outq.sv
// Small result queue in front of the output channel, so input keeps flowing during stalls.
// Depends on esr_pkg.
module esr_outq import esr_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  result_t             push_data,
    input  logic                pop_stall,
    output logic                pop_valid,
    output result_t             pop_data,
    output logic [OQ_CNT_W-1:0] count
);

    localparam logic [OQ_PTR_W-1:0] LAST_SLOT = OQ_PTR_W'(OUTQ_DEPTH - 1);

    result_t             slot_reg [OUTQ_DEPTH];
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_CNT_W-1:0] count_reg, count_next;
    logic                pop_en;

    // Pointer and count updates.
    always_comb
    begin
        pop_en      = pop_valid && !pop_stall;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_en && pop_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/edge_timed_serial_receiver.sv
// Top level of the edge-timed serial receiver: input handshake, result stage, output queue.
// Depends on esr_pkg, esr_frame, esr_fifo and esr_outq.
//
// Usage: every input item (line edge, FIFO pop, FIFO clear or rearm) is taken at a rising
// edge of clk with in_valid high and in_stall low, and yields exactly one result item on
// the output channel, taken when out_valid is high and out_stall is low.
// All state is updated in the cycle the item is accepted; the result then sits in a result
// register, together with the registered read of the character RAM, and from there it
// moves into a three-entry output queue. Throughput is one item per cycle as long as the
// receiver keeps taking results.
// When the receiver stalls, results collect in the queue; in_stall rises once the queue
// and the result register together hold three items, and drops as soon as room frees up.
// in_stall depends only on registered state, never on out_stall.
// The user writes the parity check enable register with cfg_we/cfg_wdata while idle; the block does not enforce it.
// After rst_n the receiver waits for a start bit, the FIFO is empty, overflow is clear
// and parity checking is enabled; FIFO storage is not cleared and needs no sweep.
module edge_timed_serial_receiver import esr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic              pin_level,
    input  logic [7:0]        bits_elapsed,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              char_done,
    output logic [CHAR_W-1:0] char_value,
    output logic              parity_error,
    output logic              read_valid,
    output logic [CHAR_W-1:0] read_value,
    output logic [FILL_W-1:0] fill_count,
    output logic              overflow
);

    logic                accept;
    frame_res_t          frame_res;
    logic                rd_valid;
    logic [FILL_W-1:0]   fill;
    logic                ovf;
    logic [CHAR_W-1:0]   rd_data;
    logic                s1_valid_reg;
    result_t             s1_reg;
    result_t             s1_res;
    result_t             q_data;
    logic [OQ_CNT_W-1:0] q_count;
    logic [OQ_CNT_W:0]   occupancy;

    // Back-pressure: room is needed for the item in the result stage and the one arriving.
    assign occupancy = {1'b0, q_count} + {{OQ_CNT_W{1'b0}}, s1_valid_reg};
    assign in_stall  = (occupancy >= (OQ_CNT_W + 1)'(OUTQ_DEPTH));
    assign accept    = in_valid && !in_stall;

    esr_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .step_en     (accept),
        .kind        (kind),
        .pin_level   (pin_level),
        .bits_elapsed(bits_elapsed),
        .res         (frame_res)
    );

    esr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (accept),
        .kind    (kind),
        .push    (frame_res),
        .rd_valid(rd_valid),
        .fill    (fill),
        .ovf     (ovf),
        .rd_data (rd_data)
    );

    // Result stage; the popped character joins it from the RAM read register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.char_done    <= frame_res.done;
            s1_reg.char_value   <= frame_res.done ? frame_res.value : '0;
            s1_reg.parity_error <= frame_res.perr;
            s1_reg.read_valid   <= rd_valid;
            s1_reg.read_value   <= '0;
            s1_reg.fill_count   <= fill;
            s1_reg.overflow     <= ovf;
        end
    end

    always_comb
    begin
        s1_res            = s1_reg;
        s1_res.read_value = s1_reg.read_valid ? rd_data : '0;
    end

    esr_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_en  (s1_valid_reg),
        .push_data(s1_res),
        .pop_stall(out_stall),
        .pop_valid(out_valid),
        .pop_data (q_data),
        .count    (q_count)
    );

    // Output fields.
    assign char_done    = q_data.char_done;
    assign char_value   = q_data.char_value;
    assign parity_error = q_data.parity_error;
    assign read_valid   = q_data.read_valid;
    assign read_value   = q_data.read_value;
    assign fill_count   = q_data.fill_count;
    assign overflow     = q_data.overflow;

endmodule

### tb/esr_result_checker.sv
// Result checker for the edge-timed serial receiver: watches the config port and both
// item channels, predicts every result and compares it field by field.
// Depends on esr_pkg for kind codes, widths, FIFO depth and the result type.
module esr_result_checker import esr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        kind,
    input  logic              pin_level,
    input  logic [7:0]        bits_elapsed,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              char_done,
    input  logic [CHAR_W-1:0] char_value,
    input  logic              parity_error,
    input  logic              read_valid,
    input  logic [CHAR_W-1:0] read_value,
    input  logic [FILL_W-1:0] fill_count,
    input  logic              overflow,
    output int                mismatches,
    output int                pending,
    output int                results_seen,
    output int                chars_seen,
    output int                parity_flags,
    output int                data_pops,
    output int                overflow_hits
);

    // Bit counter value that means the receiver is idle and waiting for a start bit.
    localparam logic [7:0] WAIT_START = 8'hFF;
    localparam int SHOWN_MISMATCHES = 10;

    // Own copy of the receiver state and its parity enable register.
    logic              parity_en;
    logic [7:0]        rx_bits;
    logic [7:0]        rx_mask;
    logic [7:0]        rx_build;
    logic [CHAR_W-1:0] char_ram [FIFO_DEPTH];
    int                fifo_rd;
    int                fifo_wr;
    logic              ovf_flag;

    result_t expected_q[$];
    int      err_total;
    int      n_results;
    int      n_chars;
    int      n_perr;
    int      n_pops;
    int      n_ovf;

    // Advance the predicted receiver by one accepted item and return its result.
    task automatic advance_receiver(input logic [1:0] k, input logic lvl,
                                    input logic [7:0] el, output result_t res);
        int                left;
        int                span;
        int                nxt;
        bit                next_started;
        logic [7:0]        m;
        logic [7:0]        v;
        logic              pbit;
        logic [CHAR_W-1:0] c;
        res = '0;
        case (k)
            KIND_EDGE: begin
                if (rx_bits == WAIT_START) begin
                    // A high level while idle is a start bit; a low one is ignored.
                    if (lvl) begin
                        rx_bits = 8'd0;
                        rx_mask = 8'd1;
                        rx_build = 8'd0;
                    end
                end else begin
                    // Back-fill the bits of the elapsed run, clipped to what is left.
                    left = int'(CHAR_FRAME_BITS) - int'(rx_bits[2:0]);
                    next_started = (int'(el) > left);
                    span = next_started ? left : int'(el);
                    if (!lvl && span == 0)
                        span = 1;
                    m = rx_mask;
                    v = rx_build;
                    rx_bits = rx_bits + 8'(span);
                    if (lvl) begin
                        for (int i = 0; i < span; i++) begin
                            v = v | m;
                            m = m << 1;
                        end
                        m = m << 1;
                    end else begin
                        m = m << (span - 1);
                        v = v | m;
                    end
                    rx_mask = m;
                    rx_build = v;
                    // Eight bits in: strip parity, check it and push the character.
                    if (rx_bits > 8'd7) begin
                        pbit = rx_build[7];
                        c = rx_build[CHAR_W-1:0];
                        rx_build = {1'b0, c};
                        nxt = (fifo_wr + 1) % FIFO_DEPTH;
                        if (nxt == fifo_rd) begin
                            ovf_flag = 1'b1;
                        end else begin
                            char_ram[fifo_wr] = c;
                            fifo_wr = nxt;
                        end
                        res.char_done = 1'b1;
                        res.char_value = c;
                        res.parity_error = parity_en && (pbit != ^c);
                        if (!lvl || !next_started) begin
                            rx_bits = WAIT_START;
                        end else begin
                            rx_bits = 8'd0;
                            rx_mask = 8'd1;
                            rx_build = 8'd0;
                        end
                    end
                end
            end
            KIND_POP: begin
                ovf_flag = 1'b0;
                if (fifo_rd != fifo_wr) begin
                    res.read_valid = 1'b1;
                    res.read_value = char_ram[fifo_rd];
                    fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
                end
            end
            KIND_CLEAR: begin
                fifo_rd = 0;
                fifo_wr = 0;
                ovf_flag = 1'b0;
            end
            default: begin
                rx_bits = WAIT_START;
            end
        endcase
        res.fill_count = FILL_W'((fifo_wr + FIFO_DEPTH - fifo_rd) % FIFO_DEPTH);
        res.overflow = ovf_flag;
    endtask

    // Count a differing field and report it while under the display limit.
    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_total++;
            if (err_total <= SHOWN_MISMATCHES)
                $display("%0t: mismatch in %s: expected %0d, got %0d",
                         $time, field, want, got);
        end
    endtask

    // Predict on every accepted input item, compare on every accepted result item.
    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        result_t got;
        if (!rst_n) begin
            parity_en = 1'b1;
            rx_bits = WAIT_START;
            rx_mask = 8'd0;
            rx_build = 8'd0;
            for (int i = 0; i < FIFO_DEPTH; i++)
                char_ram[i] = '0;
            fifo_rd = 0;
            fifo_wr = 0;
            ovf_flag = 1'b0;
            expected_q.delete();
            err_total = 0;
            n_results = 0;
            n_chars = 0;
            n_perr = 0;
            n_pops = 0;
            n_ovf = 0;
            mismatches <= 0;
            pending <= 0;
            results_seen <= 0;
            chars_seen <= 0;
            parity_flags <= 0;
            data_pops <= 0;
            overflow_hits <= 0;
        end else begin
            if (cfg_we)
                parity_en = cfg_wdata;
            if (in_valid && !in_stall) begin
                advance_receiver(kind, pin_level, bits_elapsed, want);
                expected_q.push_back(want);
            end
            if (out_valid && !out_stall) begin
                got = {char_done, char_value, parity_error, read_valid, read_value,
                       fill_count, overflow};
                n_results++;
                if (got.char_done)
                    n_chars++;
                if (got.parity_error)
                    n_perr++;
                if (got.read_valid)
                    n_pops++;
                if (got.overflow)
                    n_ovf++;
                if (expected_q.size() == 0) begin
                    err_total++;
                    if (err_total <= SHOWN_MISMATCHES)
                        $display("%0t: result item arrived with none expected", $time);
                end else begin
                    want = expected_q.pop_front();
                    check_field("char_done", want.char_done, got.char_done);
                    check_field("char_value", want.char_value, got.char_value);
                    check_field("parity_error", want.parity_error, got.parity_error);
                    check_field("read_valid", want.read_valid, got.read_valid);
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("fill_count", want.fill_count, got.fill_count);
                    check_field("overflow", want.overflow, got.overflow);
                end
            end
            mismatches <= err_total;
            pending <= expected_q.size();
            results_seen <= n_results;
            chars_seen <= n_chars;
            parity_flags <= n_perr;
            data_pops <= n_pops;
            overflow_hits <= n_ovf;
        end
    end

endmodule

### tb/edge_timed_serial_receiver_tb.sv
// Testbench top for the edge-timed serial receiver: clock, reset, stimulus and verdict.
// Depends on esr_pkg, the edge_timed_serial_receiver RTL and esr_result_checker.
module edge_timed_serial_receiver_tb;
    import esr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASES = 3;
    localparam int RUN_LIMIT = 5000000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        kind = KIND_EDGE;
    logic              pin_level = 1'b0;
    logic [7:0]        bits_elapsed = 8'd0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              char_done;
    logic [CHAR_W-1:0] char_value;
    logic              parity_error;
    logic              read_valid;
    logic [CHAR_W-1:0] read_value;
    logic [FILL_W-1:0] fill_count;
    logic              overflow;

    int mismatches;
    int pending;
    int results_seen;
    int chars_seen;
    int parity_flags;
    int data_pops;
    int overflow_hits;

    // Idle limits for the sender and receiver, changed per segment of the run.
    int in_max = 3;
    int out_max = 3;
    int stall_left = 0;
    int stall_draw;
    int items_sent = 0;

    // Line model for building well-formed character waveforms.
    logic line_level = 1'b0;
    int   since_edge = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    edge_timed_serial_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .pin_level    (pin_level),
        .bits_elapsed (bits_elapsed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_done    (char_done),
        .char_value   (char_value),
        .parity_error (parity_error),
        .read_valid   (read_valid),
        .read_value   (read_value),
        .fill_count   (fill_count),
        .overflow     (overflow)
    );

    esr_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .pin_level     (pin_level),
        .bits_elapsed  (bits_elapsed),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .char_done     (char_done),
        .char_value    (char_value),
        .parity_error  (parity_error),
        .read_valid    (read_valid),
        .read_value    (read_value),
        .fill_count    (fill_count),
        .overflow      (overflow),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .chars_seen    (chars_seen),
        .parity_flags  (parity_flags),
        .data_pops     (data_pops),
        .overflow_hits (overflow_hits)
    );

    // Receiver side: after each taken result, stall for a random number of cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
        else if (out_valid && !out_stall)
        begin
            stall_draw = $urandom_range(0, out_max);
            stall_left <= stall_draw;
            out_stall <= (stall_draw != 0);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_idle_limit();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 19;
        endcase
    endfunction

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_item(input logic [1:0] k, input logic lvl, input logic [7:0] el);
        int gap;
        gap = $urandom_range(0, in_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        pin_level <= lvl;
        bits_elapsed <= el;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Software items carry random payload bits that the block does not use.
    task automatic send_cmd(input logic [1:0] k);
        send_item(k, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // A stray edge with an arbitrary level and timing.
    task automatic send_noise();
        logic [7:0] el;
        case ($urandom_range(0, 3))
            0: el = 8'd0;
            1: el = 8'd255;
            2: el = 8'($urandom_range(0, 12));
            default: el = 8'($urandom_range(0, 255));
        endcase
        send_item(KIND_EDGE, 1'($urandom_range(0, 1)), el);
    endtask

    // Walk one framed character over the line model and send an edge at every
    // level change; a high level is a zero bit. Pops may fall between edges.
    task automatic send_char(input logic [CHAR_W-1:0] c, input bit bad_parity,
                             input int idle_bits, input int mid_pop_pct);
        logic [9:0] frame;
        logic       lvl;
        frame = {1'b1, (^c) ^ bad_parity, c, 1'b0};
        for (int i = 0; i < 10; i++)
        begin
            lvl = ~frame[i];
            if (lvl != line_level)
            begin
                send_item(KIND_EDGE, lvl, (since_edge > 255) ? 8'd255 : 8'(since_edge));
                since_edge = 0;
                line_level = lvl;
                if ($urandom_range(0, 99) < mid_pop_pct)
                    send_cmd(KIND_POP);
            end
            since_edge++;
        end
        since_edge += idle_bits;
    endtask

    task automatic send_random_char(input int mid_pop_pct);
        int idle;
        case ($urandom_range(0, 9))
            7, 8: idle = $urandom_range(3, 20);
            9: idle = $urandom_range(200, 300);
            default: idle = $urandom_range(0, 2);
        endcase
        send_char(CHAR_W'($urandom_range(0, 127)), ($urandom_range(0, 99) < 15), idle,
                  mid_pop_pct);
    endtask

    // One stretch of traffic with its own pop rate and idle limits.
    task automatic run_segment(input int pop_pct, input int steps, input bit allow_clear);
        int r;
        in_max = pick_idle_limit();
        out_max = pick_idle_limit();
        for (int n = 0; n < steps; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < pop_pct)
                send_cmd(KIND_POP);
            else if (allow_clear && r < pop_pct + 3)
                send_cmd(KIND_CLEAR);
            else if (allow_clear && r < pop_pct + 6)
                send_cmd(KIND_REARM);
            else if (r < pop_pct + 14)
                send_noise();
            else
                send_random_char(pop_pct / 3);
        end
    endtask

    // Stop offering items and wait until every expected result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_parity_cfg(input logic en);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= en;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase_end;
        int base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, idle low edge, rearm, saturated and zero-length runs,
        // a run past the end of the character, a start bit found from elapsed time,
        // rearm mid-character, clear, and three characters, one with bad parity and two with good.
        send_cmd(KIND_POP);
        send_item(KIND_EDGE, 1'b0, 8'd0);
        send_cmd(KIND_REARM);
        send_item(KIND_EDGE, 1'b1, 8'd255);
        send_item(KIND_EDGE, 1'b0, 8'd0);
        send_item(KIND_EDGE, 1'b1, 8'd1);
        send_item(KIND_EDGE, 1'b0, 8'd255);
        send_item(KIND_EDGE, 1'b1, 8'd3);
        send_item(KIND_EDGE, 1'b1, 8'd255);
        send_item(KIND_EDGE, 1'b0, 8'd9);
        send_cmd(KIND_POP);
        send_cmd(KIND_POP);
        send_item(KIND_EDGE, 1'b1, 8'd0);
        send_cmd(KIND_REARM);
        send_item(KIND_EDGE, 1'b1, 8'd7);
        send_item(KIND_EDGE, 1'b0, 8'd2);
        send_cmd(KIND_CLEAR);
        send_cmd(KIND_POP);
        line_level = 1'b0;
        since_edge = 40;
        send_char(7'h00, 1'b1, 1, 0);
        send_char(7'h7F, 1'b0, 0, 0);
        send_char(7'h55, 1'b0, 4, 0);

        // Random: each phase runs with its own parity setting, fills the FIFO past
        // full, drains it, then mixes traffic until its share of items is sent.
        base = items_sent;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_parity_cfg((ph == PHASES - 1) ? 1'($urandom_range(0, 1)) : 1'(ph % 2));
            phase_end = base + (ph + 1) * RANDOM_ITEMS / PHASES;
            run_segment(0, 100, 1'b0);
            run_segment(70, 30, 1'b1);
            while (items_sent < phase_end)
                run_segment($urandom_range(0, 3) * 20, 15, 1'b1);
        end

        wait_idle();
        $display("Sent %0d items; %0d results checked, %0d characters, %0d parity flags,",
                 items_sent, results_seen, chars_seen, parity_flags);
        $display("%0d pops with data and %0d results with overflow set.",
                 data_pops, overflow_hits);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
